@@ rtl/core/sqlts_pkg.sv @@
// ----------------------------------------------------------------------------
// sqlts_pkg
// Token kinds, error codes, scan modes, the token record and the keyword table
// for the SQL token scanner.
// ----------------------------------------------------------------------------
package sqlts_pkg;

  localparam logic [5:0] K_END     = 6'd0;
  localparam logic [5:0] K_LPAREN  = 6'd1;
  localparam logic [5:0] K_RPAREN  = 6'd2;
  localparam logic [5:0] K_COMMA   = 6'd3;
  localparam logic [5:0] K_SEMI    = 6'd4;
  localparam logic [5:0] K_STAR    = 6'd5;
  localparam logic [5:0] K_PLUS    = 6'd6;
  localparam logic [5:0] K_MINUS   = 6'd7;
  localparam logic [5:0] K_SLASH   = 6'd8;
  localparam logic [5:0] K_PERCENT = 6'd9;
  localparam logic [5:0] K_EQ      = 6'd10;
  localparam logic [5:0] K_NE      = 6'd11;
  localparam logic [5:0] K_LT      = 6'd12;
  localparam logic [5:0] K_LE      = 6'd13;
  localparam logic [5:0] K_GT      = 6'd14;
  localparam logic [5:0] K_GE      = 6'd15;
  localparam logic [5:0] K_ERROR   = 6'd16;
  localparam logic [5:0] K_STRING  = 6'd17;
  localparam logic [5:0] K_INTEGER = 6'd18;
  localparam logic [5:0] K_DECIMAL = 6'd19;
  localparam logic [5:0] K_IDENT   = 6'd20;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNEXP    = 3'd1;
  localparam logic [2:0] E_BANG     = 3'd2;
  localparam logic [2:0] E_STRING   = 3'd3;
  localparam logic [2:0] E_COMMENT  = 3'd4;
  localparam logic [2:0] E_OVERFLOW = 3'd5;

  localparam logic [62:0] VAL_MAX = {63{1'b1}};
  localparam int          KW_NUM  = 33;

  typedef enum logic [12:0] {
    M_IDLE       = 13'b0000000000001,
    M_IDENT      = 13'b0000000000010,
    M_NUMBER     = 13'b0000000000100,
    M_STRING     = 13'b0000000001000,
    M_ESCAPE     = 13'b0000000010000,
    M_LT         = 13'b0000000100000,
    M_GT         = 13'b0000001000000,
    M_BANG       = 13'b0000010000000,
    M_MINUS      = 13'b0000100000000,
    M_SLASH      = 13'b0001000000000,
    M_BLOCK      = 13'b0010000000000,
    M_BLOCK_STAR = 13'b0100000000000,
    M_LINE       = 13'b1000000000000
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] offset;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] column;
    logic [62:0] value;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  localparam logic [55:0] KW_KEYS [KW_NUM] = '{
    56'("SELECT"), 56'("FROM"), 56'("WHERE"), 56'("ORDER"), 56'("BY"),
    56'("ASC"), 56'("DESC"), 56'("LIMIT"), 56'("OFFSET"), 56'("INSERT"),
    56'("INTO"), 56'("VALUES"), 56'("CREATE"), 56'("TABLE"), 56'("DROP"),
    56'("AND"), 56'("OR"), 56'("NOT"), 56'("NULL"), 56'("TRUE"),
    56'("FALSE"), 56'("COUNT"), 56'("SUM"), 56'("MIN"), 56'("MAX"),
    56'("AVG"), 56'("INT"), 56'("INTEGER"), 56'("TEXT"), 56'("FLOAT"),
    56'("BOOLEAN"), 56'("BOOL"), 56'("BLOB")
  };
  localparam logic [5:0] KW_KINDS [KW_NUM] = '{
    6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
    6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
    6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50,
    6'd51, 6'd51, 6'd52
  };

  // Map a collected identifier to its keyword kind, or plain identifier.
  function automatic logic [5:0] keyword_kind(input logic [55:0] chars,
                                              input logic overlong);
    logic [5:0] k;
    k = K_IDENT;
    if (!overlong) begin
      for (int i = 0; i < KW_NUM; i++) begin
        if (KW_KEYS[i] == chars) k = KW_KINDS[i];
      end
    end
    return k;
  endfunction

endpackage

@@ rtl/core/sqlts_if.sv @@
// ----------------------------------------------------------------------------
// sqlts_in_if / sqlts_out_if
// Valid/ready channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------
interface sqlts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_mark;
  modport source (output valid, text_byte, end_mark, input ready);
  modport sink   (input valid, text_byte, end_mark, output ready);
endinterface

interface sqlts_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [2:0]  error_code;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [62:0] token_value;
  logic        last_of_run;
  modport source (output valid, token_kind, error_code, start_offset, token_length,
                  token_line, token_column, token_value, last_of_run, input ready);
  modport sink   (input valid, token_kind, error_code, start_offset, token_length,
                  token_line, token_column, token_value, last_of_run, output ready);
endinterface

@@ rtl/core/sqlts_scan.sv @@
// ----------------------------------------------------------------------------
// sqlts_scan
// Scanner state and the per-byte step; yields up to two tokens per byte.
// ----------------------------------------------------------------------------
module sqlts_scan #(
  parameter int POS_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        text_byte,
  input  logic              end_mark,
  output sqlts_pkg::push_t  push
);
  import sqlts_pkg::*;

  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
  localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

  mode_t                mode, mode_next;
  logic                 dq, dq_next;
  logic [55:0]          kw, kw_next;
  logic                 overlong, overlong_next;
  logic [POS_WIDTH-1:0] ts_off, ts_off_next, ts_line, ts_line_next;
  logic [POS_WIDTH-1:0] ts_col, ts_col_next, len, len_next;
  logic [POS_WIDTH-1:0] cur_off, cur_off_next, cur_line, cur_line_next;
  logic [POS_WIDTH-1:0] cur_col, cur_col_next;
  logic [62:0]          acc, acc_next;
  logic                 ovf, ovf_next, dot, dot_next, unclosed, unclosed_next;

  function automatic logic [15:0] lo16(input logic [POS_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  always_comb begin
    tok_t        t [2];
    logic [1:0]  n;
    logic        rescan, escaped;
    logic [7:0]  b, up;
    logic [66:0] prod;
    logic [15:0] so, sl, sc;

    t[0] = '0;
    t[1] = '0;
    n = 2'd0;
    rescan = 1'b0;
    escaped = 1'b0;
    b = text_byte;
    up = (b inside {["a":"z"]}) ? b - 8'd32 : b;
    prod = 67'({acc, 3'b000}) + 67'({acc, 1'b0}) + 67'(b - 8'h30);
    so = lo16(ts_off);
    sl = lo16(ts_line);
    sc = lo16(ts_col);

    mode_next = mode;         dq_next = dq;           kw_next = kw;
    overlong_next = overlong; ts_off_next = ts_off;   ts_line_next = ts_line;
    ts_col_next = ts_col;     len_next = len;         cur_off_next = cur_off;
    cur_line_next = cur_line; cur_col_next = cur_col; acc_next = acc;
    ovf_next = ovf;           dot_next = dot;         unclosed_next = unclosed;

    if (end_mark) begin
      // Flush the pending token, then the end token at the current position.
      case (mode)
        M_IDENT: begin
          t[0] = '{keyword_kind(kw, overlong), E_NONE, so, lo16(len), sl, sc, '0, 1'b0};
          n = 2'd1;
        end
        M_NUMBER: begin
          if (dot) t[0] = '{K_DECIMAL, E_NONE, so, lo16(len), sl, sc, '0, 1'b0};
          else t[0] = '{K_INTEGER, ovf ? E_OVERFLOW : E_NONE, so, lo16(len), sl, sc,
                        acc, 1'b0};
          n = 2'd1;
        end
        M_STRING, M_ESCAPE: begin
          t[0] = '{K_ERROR, E_STRING, so, lo16(len), sl, sc, '0, 1'b0};
          n = 2'd1;
        end
        M_LT: begin t[0] = '{K_LT, E_NONE, so, 16'd1, sl, sc, '0, 1'b0}; n = 2'd1; end
        M_GT: begin t[0] = '{K_GT, E_NONE, so, 16'd1, sl, sc, '0, 1'b0}; n = 2'd1; end
        M_BANG: begin t[0] = '{K_ERROR, E_BANG, so, 16'd1, sl, sc, '0, 1'b0}; n = 2'd1; end
        M_MINUS: begin
          t[0] = '{K_MINUS, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
          n = 2'd1;
        end
        M_SLASH: begin
          t[0] = '{K_SLASH, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
          n = 2'd1;
        end
        default: ;
      endcase
      t[n[0]] = '{K_END, unclosed ? E_COMMENT : E_NONE, lo16(cur_off), 16'd0,
                  lo16(cur_line), lo16(cur_col), '0, 1'b1};
      n = n + 2'd1;
      mode_next = M_IDLE;     dq_next = 1'b0;        kw_next = '0;
      overlong_next = 1'b0;   ts_off_next = '0;      ts_line_next = POS_ONE;
      ts_col_next = POS_ONE;  len_next = '0;         cur_off_next = '0;
      cur_line_next = POS_ONE; cur_col_next = POS_ONE; acc_next = '0;
      ovf_next = 1'b0;        dot_next = 1'b0;       unclosed_next = 1'b0;
    end else begin
      case (mode)
        M_IDLE: rescan = 1'b1;
        M_IDENT: begin
          if (b inside {["A":"Z"], ["a":"z"], "_", ["0":"9"]}) begin
            if (len < POS_WIDTH'(7)) kw_next = {kw[47:0], up};
            else overlong_next = 1'b1;
            len_next = sat_inc(len);
          end else begin
            t[0] = '{keyword_kind(kw, overlong), E_NONE, so, lo16(len), sl, sc, '0, 1'b0};
            n = 2'd1;
            rescan = 1'b1;
          end
        end
        M_NUMBER: begin
          if (b inside {["0":"9"]}) begin
            if (!dot && !ovf) begin
              if (prod > 67'(VAL_MAX)) begin
                ovf_next = 1'b1;
                acc_next = VAL_MAX;
              end else begin
                acc_next = prod[62:0];
              end
            end
            len_next = sat_inc(len);
          end else if (b == "." && !dot) begin
            dot_next = 1'b1;
            len_next = sat_inc(len);
          end else begin
            if (dot) t[0] = '{K_DECIMAL, E_NONE, so, lo16(len), sl, sc, '0, 1'b0};
            else t[0] = '{K_INTEGER, ovf ? E_OVERFLOW : E_NONE, so, lo16(len), sl, sc,
                          acc, 1'b0};
            n = 2'd1;
            rescan = 1'b1;
          end
        end
        M_STRING: begin
          if (b == (dq ? 8'h22 : 8'h27)) begin
            len_next = sat_inc(len);
            t[0] = '{K_STRING, E_NONE, so, lo16(sat_inc(len)), sl, sc, '0, 1'b0};
            n = 2'd1;
            mode_next = M_IDLE;
          end else if (b == 8'h0A) begin
            t[0] = '{K_ERROR, E_STRING, so, lo16(len), sl, sc, '0, 1'b0};
            n = 2'd1;
            rescan = 1'b1;
          end else begin
            if (b == 8'h5C) mode_next = M_ESCAPE;
            len_next = sat_inc(len);
          end
        end
        M_ESCAPE: begin
          escaped = 1'b1;
          len_next = sat_inc(len);
          mode_next = M_STRING;
        end
        M_LT: begin
          if (b == "=" || b == ">") begin
            t[0] = '{(b == "=") ? K_LE : K_NE, E_NONE, so, 16'd2, sl, sc, '0, 1'b0};
            n = 2'd1;
            mode_next = M_IDLE;
          end else begin
            t[0] = '{K_LT, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
            n = 2'd1;
            rescan = 1'b1;
          end
        end
        M_GT, M_BANG: begin
          if (b == "=") begin
            t[0] = '{(mode == M_GT) ? K_GE : K_NE, E_NONE, so, 16'd2, sl, sc, '0, 1'b0};
            n = 2'd1;
            mode_next = M_IDLE;
          end else begin
            if (mode == M_GT) t[0] = '{K_GT, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
            else t[0] = '{K_ERROR, E_BANG, so, 16'd1, sl, sc, '0, 1'b0};
            n = 2'd1;
            rescan = 1'b1;
          end
        end
        M_MINUS: begin
          if (b == "-") mode_next = M_LINE;
          else begin
            t[0] = '{K_MINUS, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
            n = 2'd1;
            rescan = 1'b1;
          end
        end
        M_SLASH: begin
          if (b == "*") begin
            mode_next = M_BLOCK;
            unclosed_next = 1'b1;
          end else begin
            t[0] = '{K_SLASH, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
            n = 2'd1;
            rescan = 1'b1;
          end
        end
        M_BLOCK: if (b == "*") mode_next = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (b == "/") begin
            mode_next = M_IDLE;
            unclosed_next = 1'b0;
          end else if (b != "*") begin
            mode_next = M_BLOCK;
          end
        end
        M_LINE: if (b == 8'h0A) mode_next = M_IDLE;
        default: rescan = 1'b1;
      endcase

      if (rescan) begin
        mode_next = M_IDLE;
        if (!(b inside {8'h20, 8'h09, 8'h0D, 8'h0A})) begin
          ts_off_next = cur_off;
          ts_line_next = cur_line;
          ts_col_next = cur_col;
          len_next = POS_ONE;
          so = lo16(cur_off);
          sl = lo16(cur_line);
          sc = lo16(cur_col);
          case (b)
            "(": begin t[n[0]] = '{K_LPAREN, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
                 n = n + 2'd1; end
            ")": begin t[n[0]] = '{K_RPAREN, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
                 n = n + 2'd1; end
            ",": begin t[n[0]] = '{K_COMMA, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
                 n = n + 2'd1; end
            ";": begin t[n[0]] = '{K_SEMI, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
                 n = n + 2'd1; end
            "*": begin t[n[0]] = '{K_STAR, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
                 n = n + 2'd1; end
            "+": begin t[n[0]] = '{K_PLUS, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
                 n = n + 2'd1; end
            "%": begin t[n[0]] = '{K_PERCENT, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
                 n = n + 2'd1; end
            "=": begin t[n[0]] = '{K_EQ, E_NONE, so, 16'd1, sl, sc, '0, 1'b0};
                 n = n + 2'd1; end
            "-": mode_next = M_MINUS;
            "/": mode_next = M_SLASH;
            "<": mode_next = M_LT;
            ">": mode_next = M_GT;
            "!": mode_next = M_BANG;
            8'h27, 8'h22: begin
              dq_next = (b == 8'h22);
              mode_next = M_STRING;
            end
            default: begin
              if (b inside {["0":"9"]}) begin
                acc_next = 63'(b - 8'h30);
                ovf_next = 1'b0;
                dot_next = 1'b0;
                mode_next = M_NUMBER;
              end else if (b inside {["A":"Z"], ["a":"z"], "_"}) begin
                kw_next = 56'(up);
                overlong_next = 1'b0;
                mode_next = M_IDENT;
              end else begin
                t[n[0]] = '{K_ERROR, E_UNEXP, so, 16'd1, sl, sc, '0, 1'b0};
                n = n + 2'd1;
              end
            end
          endcase
        end
      end

      // Advance the position counters.
      cur_off_next = sat_inc(cur_off);
      if (b == 8'h0A && !escaped) begin
        cur_line_next = sat_inc(cur_line);
        cur_col_next = POS_ONE;
      end else begin
        cur_col_next = sat_inc(cur_col);
      end
      if (n != 2'd0) t[n[0] ^ 1'b1].last = 1'b1;
    end

    push.cnt = accept ? n : 2'd0;
    push.t0 = t[0];
    push.t1 = t[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;     dq <= 1'b0;        kw <= '0;
      overlong <= 1'b0;   ts_off <= '0;      ts_line <= POS_ONE;
      ts_col <= POS_ONE;  len <= '0;         cur_off <= '0;
      cur_line <= POS_ONE; cur_col <= POS_ONE; acc <= '0;
      ovf <= 1'b0;        dot <= 1'b0;       unclosed <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;         dq <= dq_next;           kw <= kw_next;
      overlong <= overlong_next; ts_off <= ts_off_next;   ts_line <= ts_line_next;
      ts_col <= ts_col_next;     len <= len_next;         cur_off <= cur_off_next;
      cur_line <= cur_line_next; cur_col <= cur_col_next; acc <= acc_next;
      ovf <= ovf_next;           dot <= dot_next;         unclosed <= unclosed_next;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && end_mark |=> mode == M_IDLE && cur_off == '0 && !unclosed)
    else $error("scanner not back at start after end of text");
  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    accept && end_mark |-> push.cnt != 2'd0)
    else $error("end of text produced no token");
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_line != '0 && cur_col != '0)
    else $error("line or column counter reached zero");
endmodule

@@ rtl/core/sqlts_outq.sv @@
// ----------------------------------------------------------------------------
// sqlts_outq
// Four-entry token queue: takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
module sqlts_outq (
  input  logic             clk,
  input  logic             rst,
  input  sqlts_pkg::push_t push,
  output logic             space,
  output logic             valid,
  input  logic             ready,
  output sqlts_pkg::tok_t  head
);
  import sqlts_pkg::*;

  tok_t       mem [4];
  logic [1:0] wr, rd;
  logic [2:0] cnt;
  logic       pop;

  assign pop   = valid && ready;
  assign valid = (cnt != 3'd0);
  assign space = (cnt <= 3'd2);
  assign head  = mem[rd];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr] <= push.t0;
    if (push.cnt == 2'd2) mem[wr + 2'd1] <= push.t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      cnt <= '0;
    end else begin
      wr <= wr + push.cnt;
      rd <= rd + 2'(pop);
      cnt <= cnt + 3'(push.cnt) - 3'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("token queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> cnt <= 3'd2)
    else $error("push without room");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && push.cnt == 2'd0 |=> cnt == $past(cnt) - 3'd1)
    else $error("queue count did not drop on pop");
endmodule

@@ rtl/core/sql_token_scanner.sv @@
// ----------------------------------------------------------------------------
// sql_token_scanner
// Lexes SQL text one byte per transaction and returns tokens with position.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | note
//  in_ch    | in  | text_byte, end_mark                              | 1 byte
//  out_ch   | out | token_kind, error_code, start_offset,            | 0..2 per
//           |     | token_length, token_line, token_column,          | byte
//           |     | token_value, last_of_run                         |
//
// One byte can be taken every cycle; its tokens are written into a four-entry
// queue at the accepting edge and can leave from the next edge on, one per
// cycle while out_ch is ready. The scanner step is a single registered pass;
// the queue's one read port sets the output rate.
// Reset (rst, synchronous) returns the scanner to line 1, column 1 and empties
// the queue. in_ch stalls whenever fewer than two queue entries are free.
// ----------------------------------------------------------------------------
module sql_token_scanner #(
  parameter int POS_WIDTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  sqlts_in_if.sink    in_ch,
  sqlts_out_if.source out_ch
);
  import sqlts_pkg::*;

  push_t push;
  tok_t  head;
  logic  space;

  // Take a byte only when the queue can hold both tokens it may cause.
  assign in_ch.ready = space;

  sqlts_scan #(.POS_WIDTH(POS_WIDTH)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_ch.valid && in_ch.ready),
    .text_byte (in_ch.text_byte),
    .end_mark  (in_ch.end_mark),
    .push      (push)
  );

  sqlts_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .space (space),
    .valid (out_ch.valid),
    .ready (out_ch.ready),
    .head  (head)
  );

  // Unpack the head token onto the output transaction.
  assign out_ch.token_kind   = head.kind;
  assign out_ch.error_code   = head.err;
  assign out_ch.start_offset = head.offset;
  assign out_ch.token_length = head.len;
  assign out_ch.token_line   = head.line;
  assign out_ch.token_column = head.column;
  assign out_ch.token_value  = head.value;
  assign out_ch.last_of_run  = head.last;
endmodule

@@ dv/sqlts_scan_checker.sv @@
// ----------------------------------------------------------------------------
// sqlts_scan_checker
// Watches both channels of the SQL token scanner, predicts the tokens of
// every accepted text byte and compares them with the tokens that come out.
// ----------------------------------------------------------------------------
module sqlts_scan_checker (
  input  logic  clk,
  input  logic  rst,
  sqlts_in_if   in_ch,
  sqlts_out_if  out_ch,
  output int    fail_count,
  output int    tokens_checked,
  output int    tokens_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import sqlts_pkg::*;

  tok_t expected_tokens[$];

  mode_t       mode;
  bit          quote_dq, kw_overlong, int_ovf, has_dot, comment_open;
  logic [55:0] kw_chars;
  logic [15:0] tok_off, tok_line, tok_col, tok_len;
  logic [15:0] pos_off, pos_line, pos_col;
  logic [62:0] int_acc;
  int          step_tokens;

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [5:0] word_kind();
    logic [5:0] k;
    k = K_IDENT;
    if (!kw_overlong) begin
      for (int i = 0; i < KW_NUM; i++) begin
        if (KW_KEYS[i] == kw_chars) k = KW_KINDS[i];
      end
    end
    return k;
  endfunction

  task automatic clear_scan();
    mode = M_IDLE;
    quote_dq = 0; kw_chars = '0; kw_overlong = 0;
    tok_off = 16'd0; tok_line = 16'd1; tok_col = 16'd1; tok_len = 16'd0;
    pos_off = 16'd0; pos_line = 16'd1; pos_col = 16'd1;
    int_acc = '0; int_ovf = 0; has_dot = 0; comment_open = 0;
  endtask

  task automatic add_token(logic [5:0] kind, logic [2:0] err, logic [15:0] len,
                           logic [62:0] val);
    tok_t t;
    t.kind = kind; t.err = err; t.offset = tok_off; t.len = len;
    t.line = tok_line; t.column = tok_col; t.value = val; t.last = 1'b0;
    expected_tokens = {expected_tokens, t};
    step_tokens++;
  endtask

  task automatic add_number();
    if (has_dot) add_token(K_DECIMAL, E_NONE, tok_len, '0);
    else add_token(K_INTEGER, int_ovf ? E_OVERFLOW : E_NONE, tok_len, int_acc);
  endtask

  // Scan a byte with no token pending.
  task automatic scan_fresh(logic [7:0] b);
    if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A) return;
    tok_off = pos_off; tok_line = pos_line; tok_col = pos_col; tok_len = 16'd1;
    case (b)
      "(": add_token(K_LPAREN, E_NONE, 16'd1, '0);
      ")": add_token(K_RPAREN, E_NONE, 16'd1, '0);
      ",": add_token(K_COMMA, E_NONE, 16'd1, '0);
      ";": add_token(K_SEMI, E_NONE, 16'd1, '0);
      "*": add_token(K_STAR, E_NONE, 16'd1, '0);
      "+": add_token(K_PLUS, E_NONE, 16'd1, '0);
      "%": add_token(K_PERCENT, E_NONE, 16'd1, '0);
      "=": add_token(K_EQ, E_NONE, 16'd1, '0);
      "-": mode = M_MINUS;
      "/": mode = M_SLASH;
      "<": mode = M_LT;
      ">": mode = M_GT;
      "!": mode = M_BANG;
      "'", "\"": begin
        quote_dq = (b == "\"");
        mode = M_STRING;
      end
      default: begin
        if (is_num(b)) begin
          int_acc = 63'(b - "0"); int_ovf = 0; has_dot = 0; mode = M_NUMBER;
        end else if (is_letter(b)) begin
          kw_chars = 56'(upcase(b)); kw_overlong = 0; mode = M_IDENT;
        end else begin
          add_token(K_ERROR, E_UNEXP, 16'd1, '0);
        end
      end
    endcase
  endtask

  // Continue the pending token; rescan is set when the byte must start afresh.
  task automatic scan_pending(logic [7:0] b, output bit rescan, inout bit escaped);
    logic [63:0] d;
    rescan = 0;
    case (mode)
      M_IDENT: begin
        if (is_letter(b) || is_num(b)) begin
          if (tok_len < 16'd7) kw_chars = {kw_chars[47:0], upcase(b)};
          else kw_overlong = 1;
          tok_len = bump(tok_len);
          return;
        end
        add_token(word_kind(), E_NONE, tok_len, '0);
      end
      M_NUMBER: begin
        if (is_num(b)) begin
          d = 64'(b - "0");
          if (!has_dot && !int_ovf) begin
            if ({1'b0, int_acc} > ({1'b0, VAL_MAX} - d) / 64'd10) begin
              int_ovf = 1; int_acc = VAL_MAX;
            end else begin
              int_acc = 63'(int_acc * 63'd10 + 63'(d));
            end
          end
          tok_len = bump(tok_len);
          return;
        end
        if (b == "." && !has_dot) begin
          has_dot = 1; tok_len = bump(tok_len);
          return;
        end
        add_number();
      end
      M_STRING: begin
        if (b == (quote_dq ? "\"" : "'")) begin
          tok_len = bump(tok_len);
          add_token(K_STRING, E_NONE, tok_len, '0);
          mode = M_IDLE;
          return;
        end
        if (b != 8'h0A) begin
          if (b == "\\") mode = M_ESCAPE;
          tok_len = bump(tok_len);
          return;
        end
        add_token(K_ERROR, E_STRING, tok_len, '0);
      end
      M_ESCAPE: begin
        escaped = 1; tok_len = bump(tok_len); mode = M_STRING;
        return;
      end
      M_LT: begin
        if (b == "=" || b == ">") begin
          add_token(b == "=" ? K_LE : K_NE, E_NONE, 16'd2, '0);
          mode = M_IDLE;
          return;
        end
        add_token(K_LT, E_NONE, 16'd1, '0);
      end
      M_GT, M_BANG: begin
        if (b == "=") begin
          add_token(mode == M_GT ? K_GE : K_NE, E_NONE, 16'd2, '0);
          mode = M_IDLE;
          return;
        end
        if (mode == M_GT) add_token(K_GT, E_NONE, 16'd1, '0);
        else add_token(K_ERROR, E_BANG, 16'd1, '0);
      end
      M_MINUS: begin
        if (b == "-") begin mode = M_LINE; return; end
        add_token(K_MINUS, E_NONE, 16'd1, '0);
      end
      M_SLASH: begin
        if (b == "*") begin mode = M_BLOCK; comment_open = 1; return; end
        add_token(K_SLASH, E_NONE, 16'd1, '0);
      end
      M_BLOCK: begin
        if (b == "*") mode = M_BLOCK_STAR;
        return;
      end
      M_BLOCK_STAR: begin
        if (b == "/") begin mode = M_IDLE; comment_open = 0; end
        else if (b != "*") mode = M_BLOCK;
        return;
      end
      M_LINE: begin
        if (b == 8'h0A) mode = M_IDLE;
        return;
      end
      default: ;
    endcase
    mode = M_IDLE;
    rescan = 1;
  endtask

  task automatic predict_byte(logic [7:0] b, logic end_mark);
    bit escaped, rescan;
    escaped = 0;
    step_tokens = 0;
    if (end_mark) begin
      case (mode)
        M_IDENT:          add_token(word_kind(), E_NONE, tok_len, '0);
        M_NUMBER:         add_number();
        M_STRING, M_ESCAPE: add_token(K_ERROR, E_STRING, tok_len, '0);
        M_LT:             add_token(K_LT, E_NONE, 16'd1, '0);
        M_GT:             add_token(K_GT, E_NONE, 16'd1, '0);
        M_BANG:           add_token(K_ERROR, E_BANG, 16'd1, '0);
        M_MINUS:          add_token(K_MINUS, E_NONE, 16'd1, '0);
        M_SLASH:          add_token(K_SLASH, E_NONE, 16'd1, '0);
        default: ;
      endcase
      tok_off = pos_off; tok_line = pos_line; tok_col = pos_col;
      add_token(K_END, comment_open ? E_COMMENT : E_NONE, 16'd0, '0);
      expected_tokens[$].last = 1'b1;
      clear_scan();
      return;
    end
    if (mode == M_IDLE) begin
      scan_fresh(b);
    end else begin
      scan_pending(b, rescan, escaped);
      if (rescan) scan_fresh(b);
    end
    pos_off = bump(pos_off);
    if (b == 8'h0A && !escaped) begin
      pos_line = bump(pos_line); pos_col = 16'd1;
    end else begin
      pos_col = bump(pos_col);
    end
    if (step_tokens > 0) expected_tokens[$].last = 1'b1;
  endtask

  task automatic check_field(string name, logic [62:0] want, logic [62:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_token();
    tok_t want;
    if (expected_tokens.size() == 0) begin
      $error("token kind %0d arrived with nothing expected", out_ch.token_kind);
      fail_count++;
      return;
    end
    want = expected_tokens.pop_front();
    tokens_checked++;
    check_field("token_kind", 63'(want.kind), 63'(out_ch.token_kind));
    check_field("error_code", 63'(want.err), 63'(out_ch.error_code));
    check_field("start_offset", 63'(want.offset), 63'(out_ch.start_offset));
    check_field("token_length", 63'(want.len), 63'(out_ch.token_length));
    check_field("token_line", 63'(want.line), 63'(out_ch.token_line));
    check_field("token_column", 63'(want.column), 63'(out_ch.token_column));
    check_field("token_value", want.value, out_ch.token_value);
    check_field("last_of_run", 63'(want.last), 63'(out_ch.last_of_run));
  endtask

  initial begin
    fail_count = 0;
    tokens_checked = 0;
    clear_scan();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      expected_tokens.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_token();
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        predict_byte(in_ch.text_byte, in_ch.end_mark);
    end
    tokens_owed = expected_tokens.size();
  end

endmodule

@@ dv/sql_token_scanner_tb.sv @@
// ----------------------------------------------------------------------------
// sql_token_scanner_tb
// Feeds SQL text to the token scanner: a directed set of statements and corner
// cases, then random well-formed token streams mixed with noise bytes. Both
// channels idle and stall at random; a checker predicts and compares tokens.
// ----------------------------------------------------------------------------
module sql_token_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sqlts_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles with no transaction at all
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off

  logic clk;
  logic rst;

  sqlts_in_if  in_ch();
  sqlts_out_if out_ch();

  int fail_count, tokens_checked, tokens_owed;
  int send_gap_max, recv_gap_max;
  int bytes_sent, ends_sent;
  bit hold_request;
  int quiet_cycles;

  logic [7:0] text_q[$];

  sql_token_scanner u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sqlts_scan_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .tokens_checked (tokens_checked),
    .tokens_owed    (tokens_owed)
  );

  always #5 clk = ~clk;

  // Watchdog: a healthy run moves a transaction on one channel or the other
  // well within the limit, even through the long hold-off.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("sql_token_scanner test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte and hold it until the scanner takes it. Ready is looked at
  // on the falling edge, so the decision never races the rising edge.
  task automatic send_item(logic [7:0] b, logic end_mark);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.end_mark  <= end_mark;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    if (end_mark) ends_sent++;
    else bytes_sent++;
  endtask

  task automatic append_byte(logic [7:0] b);
    text_q = {text_q, b};
  endtask

  task automatic put(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  // Drain the collected text into the scanner, optionally closing the run.
  task automatic flush_text(bit close_run);
    while (text_q.size() > 0) send_item(text_q.pop_front(), 1'b0);
    if (close_run) send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? "a" + c : "A" + c;
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  // Append one random fragment: mostly real tokens, some broken ones and noise.
  task automatic put_fragment();
    string words[33];
    string ops[14];
    string w;
    int pick, n;
    words = '{"SELECT", "FROM", "WHERE", "ORDER", "BY", "ASC", "DESC", "LIMIT",
              "OFFSET", "INSERT", "INTO", "VALUES", "CREATE", "TABLE", "DROP",
              "AND", "OR", "NOT", "NULL", "TRUE", "FALSE", "COUNT", "SUM", "MIN",
              "MAX", "AVG", "INT", "INTEGER", "TEXT", "FLOAT", "BOOLEAN", "BOOL",
              "BLOB"};
    ops = '{"(", ")", ",", ";", "*", "+", "-", "/", "%", "=", "<", "<=", ">=", "<>"};
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // keyword, mixed case, sometimes with a tail that spoils it
      w = words[$urandom_range(0, 32)];
      for (int i = 0; i < w.len(); i++)
        append_byte(($urandom_range(0, 1) && w[i] >= "A") ? w[i] + 8'd32 : w[i]);
      if ($urandom_range(0, 4) == 0) append_byte(rand_letter());
    end else if (pick < 32) begin
      append_byte($urandom_range(0, 5) == 0 ? "_" : rand_letter());
      n = $urandom_range(0, 11);
      repeat (n) append_byte($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
    end else if (pick < 47) begin
      n = $urandom_range(0, 3) == 0 ? $urandom_range(17, 24) : $urandom_range(1, 6);
      repeat (n) append_byte(rand_digit());
      if ($urandom_range(0, 3) == 0) begin
        append_byte(".");
        repeat ($urandom_range(0, 3)) append_byte(rand_digit());
        if ($urandom_range(0, 3) == 0) append_byte(".");
      end
    end else if (pick < 60) begin
      // quoted string with escapes; now and then broken by a newline or left open
      w = $urandom_range(0, 1) ? "'" : "\"";
      put(w);
      repeat ($urandom_range(0, 8)) begin
        n = $urandom_range(0, 9);
        if (n == 0) begin
          append_byte("\\");
          append_byte(8'($urandom_range(0, 255)));
        end
        else if (n == 1) append_byte($urandom_range(0, 1) ? "'" : "\"");
        else if (n == 2 && $urandom_range(0, 3) == 0) append_byte(8'h0A);
        else append_byte(8'($urandom_range(32, 126)));
      end
      if ($urandom_range(0, 5) != 0) put(w);
    end else if (pick < 78) begin
      put(ops[$urandom_range(0, 13)]);
    end else if (pick < 84) begin
      if ($urandom_range(0, 1)) put("!=");
      else put("!");
    end else if (pick < 90) begin
      if ($urandom_range(0, 1)) begin
        put("--");
        repeat ($urandom_range(0, 6)) append_byte(8'($urandom_range(32, 126)));
        append_byte(8'h0A);
      end else begin
        put("/*");
        repeat ($urandom_range(0, 6)) append_byte($urandom_range(0, 1) ? "*" : "q");
        if ($urandom_range(0, 4) != 0) put("*/");
      end
    end else begin
      repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(0, 255)));
    end
    // separator: usually a blank, sometimes nothing so tokens touch
    case ($urandom_range(0, 5))
      0: ;
      1: append_byte(8'h0A);
      2: append_byte(8'h09);
      3: append_byte(8'h0D);
      default: append_byte(" ");
    endcase
  endtask

  // Receiver: stall a random number of cycles before each token, and when asked
  // hold off for a long stretch so the scanner backs up into its input.
  initial begin
    int stall;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = $urandom_range(0, recv_gap_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_ch.valid);
      @(posedge clk);
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.text_byte = 8'h00;
    in_ch.end_mark = 1'b0;
    out_ch.ready = 1'b0;
    send_gap_max = 3;
    recv_gap_max = 3;
    bytes_sent = 0;
    ends_sent = 0;
    hold_request = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a plain statement, every operator, keywords by case and length,
    // strings with escapes and an escaped newline, numbers at the edges.
    put("SELECT a_1, count(*) FROM tbl WHERE x<=10 AND y<>2.5;");
    put(" boolean Bool blob integer INTEGERS _x9\n");
    put("'it\\'s' \"a\\\nb\" 'open\n");
    put("!= ! = >= > < <x -- note\n/* c ** */ 7%3-1/2+a");
    put(" 1.2.3 9223372036854775807 9223372036854775808 99999999999999999999999 ");
    append_byte("@"); append_byte(8'hFF); append_byte(8'h80);
    append_byte(8'h00); append_byte(8'h7F);
    flush_text(1'b1);
    put("/* open");             flush_text(1'b1);
    put("'x\\");                flush_text(1'b1);
    put("abc");                 flush_text(1'b1);
    put("<");                   flush_text(1'b1);
    put("!");                   flush_text(1'b1);
    put("-- tail");             flush_text(1'b1);
    put("12.");                 flush_text(1'b1);
    flush_text(1'b1);

    // Random: well-formed token streams with broken pieces and noise mixed in;
    // idle patterns change per stretch, including stretches with no idling.
    while (bytes_sent < 800) begin
      case ($urandom_range(0, 3))
        0: send_gap_max = 0;
        1: send_gap_max = 3;
        default: send_gap_max = 17;
      endcase
      case ($urandom_range(0, 3))
        0: recv_gap_max = 0;
        1: recv_gap_max = 3;
        default: recv_gap_max = 17;
      endcase
      if (bytes_sent > 400 && bytes_sent < 430) begin
        send_gap_max = 0;
        hold_request = 1;
      end
      repeat ($urandom_range(1, 6)) put_fragment();
      flush_text($urandom_range(0, 7) == 0);
    end
    flush_text(1'b1);
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (tokens_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Scanned %0d text bytes over %0d runs; %0d tokens compared.",
             bytes_sent, ends_sent, tokens_checked);
    $display("Covered operators, keywords, strings, numbers, comments, noise and stalls.");
    if (fail_count == 0 && tokens_owed == 0) begin
      $display("sql_token_scanner test passed");
    end else begin
      $display("sql_token_scanner test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sqlts_pkg.sv
rtl/core/sqlts_if.sv
rtl/core/sqlts_scan.sv
rtl/core/sqlts_outq.sv
rtl/core/sql_token_scanner.sv
dv/sqlts_scan_checker.sv
dv/sql_token_scanner_tb.sv
